FILE: sv/lfyd_pkg.sv
// lfyd_pkg: types, codes and constants shared by the deck store modules.
// No dependencies; compiled first.
`default_nettype none

package lfyd_pkg;

    // Largest store the design supports and the default size
    localparam int DEF_DECK_DEPTH = 256;

    // Fixed field widths
    localparam int ENTRY_W  = 8;
    localparam int REMAIN_W = 9;

    // 8-bit LCG: r' = r*73 + 19 mod 256
    localparam logic [7:0] LCG_MUL   = 8'd73;
    localparam logic [7:0] LCG_ADD   = 8'd19;
    localparam logic [7:0] RAND_SEED = 8'd42;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SHUFFLE = 2'd2,
        CMD_DRAW    = 2'd3
    } lfyd_cmd_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } lfyd_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW_WAIT,
        ST_SH_RAND,
        ST_SH_DIV,
        ST_SH_RD_I,
        ST_SH_RD_J,
        ST_SH_WR_I,
        ST_SH_WR_J,
        ST_RESP
    } lfyd_state_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [ENTRY_W-1:0] entry;
    } lfyd_in_t;

    typedef struct packed {
        logic [ENTRY_W-1:0]  drawn;
        logic [1:0]          status;
        logic [REMAIN_W-1:0] remaining;
    } lfyd_out_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;    // command beat taken this cycle
        logic sh_rand;   // advance LCG, load remainder unit
        logic div_step;  // one remainder bit
        logic rd_i;      // read store at i
        logic rd_j;      // read store at j, latch d[i]
        logic wr_i;      // write d[j] to i
        logic wr_j;      // write d[i] to j, step i down
        logic draw_cap;  // capture drawn entry
        logic load_out;  // move result into output register
    } lfyd_ctl_t;

    // Datapath -> controller status
    typedef struct packed {
        logic cnt_lt2;
        logic draw_empty;
        logic div_last;
        logic i_last;
        logic out_free;
    } lfyd_flags_t;

endpackage

`default_nettype wire

FILE: sv/lfyd_ctrl.sv
// lfyd_ctrl: sequencing state machine for clear, append, draw and shuffle.
// Depends on lfyd_pkg; drives lfyd_dpath through lfyd_ctl_t.
`default_nettype none

module lfyd_ctrl
    import lfyd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cmd_valid,
    input  wire logic [1:0]  cmd,
    input  wire lfyd_flags_t flags,
    output logic             cmd_ready,
    output lfyd_ctl_t        ctl
);

    lfyd_state_t state_reg;
    lfyd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (lfyd_cmd_t'(cmd))
                        CMD_SHUFFLE: state_next = flags.cnt_lt2 ? ST_RESP : ST_SH_RAND;
                        CMD_DRAW:    state_next = flags.draw_empty ? ST_RESP : ST_DRAW_WAIT;
                        default:     state_next = ST_RESP;
                    endcase
                end
            end
            ST_DRAW_WAIT: state_next = ST_RESP;
            ST_SH_RAND:   state_next = ST_SH_DIV;
            ST_SH_DIV:
            begin
                if (flags.div_last)
                begin
                    state_next = ST_SH_RD_I;
                end
            end
            ST_SH_RD_I:   state_next = ST_SH_RD_J;
            ST_SH_RD_J:   state_next = ST_SH_WR_I;
            ST_SH_WR_I:   state_next = ST_SH_WR_J;
            ST_SH_WR_J:   state_next = flags.i_last ? ST_RESP : ST_SH_RAND;
            ST_RESP:
            begin
                if (flags.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl       = '0;
        cmd_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd_ready  = 1'b1;
                ctl.accept = cmd_valid;
            end
            ST_DRAW_WAIT: ctl.draw_cap = 1'b1;
            ST_SH_RAND:   ctl.sh_rand  = 1'b1;
            ST_SH_DIV:    ctl.div_step = 1'b1;
            ST_SH_RD_I:   ctl.rd_i     = 1'b1;
            ST_SH_RD_J:   ctl.rd_j     = 1'b1;
            ST_SH_WR_I:   ctl.wr_i     = 1'b1;
            ST_SH_WR_J:   ctl.wr_j     = 1'b1;
            ST_RESP:      ctl.load_out = flags.out_free;
            default:      ctl          = '0;
        endcase
    end

    // the divider runs only between an LCG step and the swap reads
    a_div_seq: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.div_step |-> ($past(ctl.sh_rand) || $past(ctl.div_step)))
        else $error("remainder step outside shuffle sequence");

    // a result is loaded at most once per accepted command
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |=> !ctl.load_out)
        else $error("result loaded twice");

    // every swap ends with both writes in order
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_i |=> ctl.wr_j)
        else $error("swap write sequence broken");

endmodule

`default_nettype wire

FILE: sv/lfyd_dpath.sv
// lfyd_dpath: deck memory, counters, LCG, remainder unit and output register.
// Depends on lfyd_pkg; sequenced by lfyd_ctrl through lfyd_ctl_t.
`default_nettype none

module lfyd_dpath
    import lfyd_pkg::*;
#(
    parameter int DECK_DEPTH = DEF_DECK_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire lfyd_in_t  cmd_beat,
    input  wire lfyd_ctl_t ctl,
    output lfyd_flags_t    flags,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output lfyd_out_t      rsp_beat
);

    localparam int AW = $clog2(DECK_DEPTH);
    localparam int CW = $clog2(DECK_DEPTH + 1);

    // store
    logic [ENTRY_W-1:0] mem [DECK_DEPTH];
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [ENTRY_W-1:0] rd_data_reg;

    // control state
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] pos_next;
    logic [7:0]    rand_reg;
    logic [7:0]    rand_next;
    logic          rsp_valid_reg;
    logic          rsp_valid_next;

    // shuffle working registers
    logic [AW-1:0]      i_reg;
    logic [7:0]         quo_reg;
    logic [7:0]         rem_reg;
    logic [2:0]         dcnt_reg;
    logic [ENTRY_W-1:0] tmp_reg;

    // pending result and output register
    logic [ENTRY_W-1:0] res_drawn_reg;
    lfyd_sts_t          res_status_reg;
    lfyd_out_t          rsp_beat_reg;

    logic          deck_full;
    logic          draw_empty;
    logic          do_append;
    logic          do_draw_rd;
    logic [8:0]    divisor;
    logic [8:0]    rem_shift;
    logic [8:0]    rem_sub;

    assign deck_full  = (count_reg == CW'(DECK_DEPTH));
    assign draw_empty = (pos_reg >= count_reg);
    assign do_append  = ctl.accept && (cmd_beat.cmd == CMD_APPEND) && !deck_full;
    assign do_draw_rd = ctl.accept && (cmd_beat.cmd == CMD_DRAW) && !draw_empty;

    assign rand_next = 8'(rand_reg * LCG_MUL) + LCG_ADD;

    // restoring remainder, one bit per cycle
    assign divisor   = 9'(i_reg) + 9'd1;
    assign rem_shift = {rem_reg, quo_reg[7]};
    assign rem_sub   = rem_shift - divisor;

    assign flags.cnt_lt2    = (count_reg < CW'(2));
    assign flags.draw_empty = draw_empty;
    assign flags.div_last   = (dcnt_reg == 3'd0);
    assign flags.i_last     = (i_reg == AW'(1));
    assign flags.out_free   = !rsp_valid_reg || rsp_ready;

    // memory port select
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[AW-1:0];
        wr_data = cmd_beat.entry;
        if (ctl.wr_i)
        begin
            wr_en   = 1'b1;
            wr_addr = i_reg;
            wr_data = rd_data_reg;
        end
        else if (ctl.wr_j)
        begin
            wr_en   = 1'b1;
            wr_addr = rem_reg[AW-1:0];
            wr_data = tmp_reg;
        end
        else if (do_append)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        rd_en   = do_draw_rd || ctl.rd_i || ctl.rd_j;
        rd_addr = pos_reg[AW-1:0];
        if (ctl.rd_i)
        begin
            rd_addr = i_reg;
        end
        else if (ctl.rd_j)
        begin
            rd_addr = rem_reg[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // counters and LCG
    always_comb
    begin
        count_next = count_reg;
        pos_next   = pos_reg;
        if (ctl.accept)
        begin
            case (lfyd_cmd_t'(cmd_beat.cmd))
                CMD_CLEAR:
                begin
                    count_next = '0;
                    pos_next   = '0;
                end
                CMD_APPEND:
                begin
                    if (!deck_full)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                CMD_SHUFFLE: pos_next = '0;
                default:     pos_next = pos_reg;
            endcase
        end
        if (ctl.draw_cap)
        begin
            pos_next = pos_reg + CW'(1);
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (ctl.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            rand_reg      <= RAND_SEED;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            rsp_valid_reg <= rsp_valid_next;
            if (ctl.sh_rand)
            begin
                rand_reg <= rand_next;
            end
        end
    end

    // shuffle registers, pending result, output payload
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            i_reg          <= AW'(count_reg - CW'(1));
            res_drawn_reg  <= '0;
            res_status_reg <= STS_OK;
            if ((cmd_beat.cmd == CMD_APPEND) && deck_full)
            begin
                res_status_reg <= STS_FULL;
            end
            if ((cmd_beat.cmd == CMD_DRAW) && draw_empty)
            begin
                res_status_reg <= STS_EMPTY;
            end
        end
        if (ctl.sh_rand)
        begin
            quo_reg  <= rand_next;
            rem_reg  <= '0;
            dcnt_reg <= 3'd7;
        end
        if (ctl.div_step)
        begin
            rem_reg  <= (rem_shift >= divisor) ? rem_sub[7:0] : rem_shift[7:0];
            quo_reg  <= {quo_reg[6:0], 1'b0};
            dcnt_reg <= dcnt_reg - 3'd1;
        end
        if (ctl.rd_j)
        begin
            tmp_reg <= rd_data_reg;
        end
        if (ctl.wr_j)
        begin
            i_reg <= i_reg - AW'(1);
        end
        if (ctl.draw_cap)
        begin
            res_drawn_reg <= rd_data_reg;
        end
        if (ctl.load_out)
        begin
            rsp_beat_reg.drawn     <= res_drawn_reg;
            rsp_beat_reg.status    <= res_status_reg;
            rsp_beat_reg.remaining <= REMAIN_W'(count_reg - pos_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    a_pos_le_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= count_reg)
        else $error("draw position passed entry count");

    a_cnt_le_depth: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DECK_DEPTH))
        else $error("entry count above store depth");

    a_j_range: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_j |-> (9'(rem_reg) <= 9'(i_reg)))
        else $error("swap partner above current position");

    a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!rsp_valid_reg || rsp_ready))
        else $error("output register overwritten before taken");

endmodule

`default_nettype wire

FILE: sv/lcg_fisher_yates_deck.sv
// lcg_fisher_yates_deck: top level of the shuffled deck store.
// Depends on lfyd_pkg, lfyd_ctrl and lfyd_dpath.
//
// Deck store of up to DECK_DEPTH opaque 8-bit entries with four commands:
// clear, append, shuffle and draw. Every command beat returns one response
// beat carrying the drawn entry (zero unless a draw succeeded), a status
// (ok, empty on draw, full on append) and the count of entries not yet drawn.
// Commands are taken one at a time; cmd_ready is high only while the block
// is idle, and a finished response sits in an output register so the next
// command can be taken while it waits. From command beat to response
// register: clear and append go straight to the response state, a draw
// first passes a registered memory read (not on an empty deck), and a
// shuffle of N >= 2 entries runs N-1 swaps first (none for fewer entries). A
// result waits in the response state while the output register still holds
// a response not yet taken. Each swap takes an LCG step, the bit-per-cycle
// remainder unit over the 8-bit LCG value, then two reads and two writes on
// the single-port store. The store has no reset; clear only zeroes the entry
// count and draw position, and the LCG keeps its state.
`default_nettype none

module lcg_fisher_yates_deck
    import lfyd_pkg::*;
#(
    parameter int DECK_DEPTH = DEF_DECK_DEPTH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_ready,
    input  wire lfyd_in_t cmd_beat,
    output logic          rsp_valid,
    input  wire logic     rsp_ready,
    output lfyd_out_t     rsp_beat
);

    lfyd_ctl_t   ctl;
    lfyd_flags_t flags;

    // sequencer
    lfyd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_beat.cmd),
        .flags     (flags),
        .cmd_ready (cmd_ready),
        .ctl       (ctl)
    );

    // store, counters, LCG, remainder unit, response register
    lfyd_dpath #(
        .DECK_DEPTH (DECK_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_beat  (cmd_beat),
        .ctl       (ctl),
        .flags     (flags),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_beat  (rsp_beat)
    );

endmodule

`default_nettype wire

FILE: bench/tb_lcg_fisher_yates_deck.sv
// tb_lcg_fisher_yates_deck: self-checking bench for the shuffled deck store.
// Depends on lfyd_pkg and lcg_fisher_yates_deck; drives random traffic, checks
// every response beat against a built-in deck/LCG predictor.
`timescale 1ns / 1ps

module tb_lcg_fisher_yates_deck
    import lfyd_pkg::*;
();

    localparam int DEPTH = DEF_DECK_DEPTH;
    localparam int ITEMS = 850;     // random command beats after the directed rows
    localparam int CALM  = 120;     // last beats run with no idling on either side

    // Directed row: command beat plus an optional hand-typed response
    typedef struct packed {
        lfyd_in_t  beat;
        logic      known;
        lfyd_out_t want;
    } dir_row_t;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    lfyd_in_t  cmd_beat;
    logic      rsp_valid;
    logic      rsp_ready;
    lfyd_out_t rsp_beat;

    // Mirror of the block's state, advanced once per accepted command beat
    logic [7:0] mirror_deck [0:255];
    logic [8:0] mirror_count;
    logic [8:0] mirror_pos;
    logic [7:0] mirror_lcg;

    lfyd_out_t due_rsp [$];         // responses still owed, oldest first
    dir_row_t  dir_rows [$];
    int        mismatch_cnt;
    int        rand_sent;
    logic      gaps_on;             // idling allowed in this stretch
    logic      calm;                // tail of the run: no idling at all
    logic      full_done;

    lcg_fisher_yates_deck #(
        .DECK_DEPTH(DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_beat  (cmd_beat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_beat  (rsp_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop; far above the slowest legal run (full-deck shuffles plus
    // worst-case gaps and stalls on every beat).
    initial
    begin
        #8_000_000;
        $display("tb_lcg_fisher_yates_deck: FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    // Apply one command to the mirror and return the response it owes.
    // Shuffle: Fisher-Yates from the top entry down, partner j = lcg mod (i+1),
    // LCG stepped before each swap; fewer than two entries leaves LCG alone.
    function automatic lfyd_out_t deck_predict(input lfyd_in_t b);
        lfyd_out_t   r;
        int unsigned i;
        int unsigned j;
        logic [7:0]  t;
        r = '0;
        case (b.cmd)
            CMD_CLEAR:
            begin
                // store contents and LCG are kept
                mirror_count = '0;
                mirror_pos   = '0;
            end
            CMD_APPEND:
            begin
                if (mirror_count >= DEPTH)
                    r.status = STS_FULL;
                else
                begin
                    mirror_deck[mirror_count[7:0]] = b.entry;
                    mirror_count = mirror_count + 9'd1;
                end
            end
            CMD_SHUFFLE:
            begin
                if (mirror_count >= 2)
                begin
                    for (i = mirror_count - 1; i > 0; i--)
                    begin
                        mirror_lcg = mirror_lcg * LCG_MUL + LCG_ADD;
                        j = mirror_lcg % (i + 1);
                        t = mirror_deck[i];
                        mirror_deck[i] = mirror_deck[j];
                        mirror_deck[j] = t;
                    end
                end
                mirror_pos = '0;
            end
            default:
            begin
                // draw past the end: empty status, position does not move
                if (mirror_pos >= mirror_count)
                    r.status = STS_EMPTY;
                else
                begin
                    r.drawn    = mirror_deck[mirror_pos[7:0]];
                    mirror_pos = mirror_pos + 9'd1;
                end
            end
        endcase
        r.remaining = (mirror_count >= mirror_pos) ? mirror_count - mirror_pos : '0;
        return r;
    endfunction

    // Present one command beat, hold it until taken, then log what it owes.
    // A hand-typed response replaces the predicted one; the mirror advances anyway.
    task automatic issue_cmd(input lfyd_in_t b, input logic known, input lfyd_out_t want);
        lfyd_out_t pred;
        if (gaps_on && !calm && $urandom_range(0, 3) == 0)
        begin
            cmd_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_beat  <= b;
        do @(posedge clk); while (!cmd_ready);
        pred = deck_predict(b);
        due_rsp.push_back(known ? want : pred);
    endtask

    task automatic push_cmd(input lfyd_cmd_t c, input logic [7:0] e);
        lfyd_in_t b;
        b.cmd   = c;
        b.entry = e;
        calm = (rand_sent >= ITEMS - CALM);
        issue_cmd(b, 1'b0, '0);
        rand_sent++;
    endtask

    function automatic dir_row_t mk_row(input lfyd_cmd_t c, input logic [7:0] e,
                                        input logic known, input logic [7:0] d,
                                        input lfyd_sts_t s, input int rem);
        dir_row_t row;
        row.beat.cmd       = c;
        row.beat.entry     = e;
        row.known          = known;
        row.want.drawn     = d;
        row.want.status    = s;
        row.want.remaining = rem[8:0];
        return row;
    endfunction

    // Response side: check every beat taken, stall in random bursts
    task automatic check_rsp(input lfyd_out_t got);
        lfyd_out_t want;
        if (due_rsp.size() == 0)
            report_mismatch("response with nothing owed", 32'(got), 0);
        else
        begin
            want = due_rsp.pop_front();
            if (got.drawn !== want.drawn)
                report_mismatch("drawn", 32'(got.drawn), 32'(want.drawn));
            if (got.status !== want.status)
                report_mismatch("status", 32'(got.status), 32'(want.status));
            if (got.remaining !== want.remaining)
                report_mismatch("remaining", 32'(got.remaining), 32'(want.remaining));
        end
    endtask

    initial
    begin : rsp_side
        int stall_left;
        stall_left = 0;
        rsp_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                check_rsp(rsp_beat);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (gaps_on && !calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(0, 18);
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    initial
    begin : cmd_side
        int n;
        int left;
        int draws;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        cmd_beat     = '0;
        mismatch_cnt = 0;
        rand_sent    = 0;
        gaps_on      = 1'b1;
        calm         = 1'b0;
        full_done    = 1'b0;
        mirror_count = '0;
        mirror_pos   = '0;
        mirror_lcg   = RAND_SEED;

        // Directed rows. Typed responses only where obvious; the draws after
        // a real shuffle depend on the LCG and go to the predictor.
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 1, 8'h00, STS_EMPTY, 0)); // empty after reset
        dir_rows.push_back(mk_row(CMD_SHUFFLE, 8'hFF, 1, 8'h00, STS_OK,    0)); // shuffle of nothing
        dir_rows.push_back(mk_row(CMD_APPEND,  8'h00, 1, 8'h00, STS_OK,    1));
        dir_rows.push_back(mk_row(CMD_APPEND,  8'hFF, 1, 8'h00, STS_OK,    2));
        dir_rows.push_back(mk_row(CMD_CLEAR,   8'hA5, 1, 8'h00, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 1, 8'h00, STS_EMPTY, 0)); // cleared deck
        dir_rows.push_back(mk_row(CMD_APPEND,  8'h5A, 1, 8'h00, STS_OK,    1));
        dir_rows.push_back(mk_row(CMD_SHUFFLE, 8'h00, 1, 8'h00, STS_OK,    1)); // single entry
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 1, 8'h5A, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 1, 8'h00, STS_EMPTY, 0)); // past the end
        dir_rows.push_back(mk_row(CMD_SHUFFLE, 8'h00, 1, 8'h00, STS_OK,    1)); // rewinds draw
        dir_rows.push_back(mk_row(CMD_DRAW,    8'hFF, 1, 8'h5A, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_CLEAR,   8'h00, 1, 8'h00, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_APPEND,  8'h01, 1, 8'h00, STS_OK,    1));
        dir_rows.push_back(mk_row(CMD_APPEND,  8'h80, 1, 8'h00, STS_OK,    2));
        dir_rows.push_back(mk_row(CMD_APPEND,  8'h7F, 1, 8'h00, STS_OK,    3));
        dir_rows.push_back(mk_row(CMD_APPEND,  8'hFE, 1, 8'h00, STS_OK,    4));
        dir_rows.push_back(mk_row(CMD_SHUFFLE, 8'h00, 1, 8'h00, STS_OK,    4)); // first real swaps
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 0, 8'h00, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 0, 8'h00, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 0, 8'h00, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 0, 8'h00, STS_OK,    0));
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 1, 8'h00, STS_EMPTY, 0));
        dir_rows.push_back(mk_row(CMD_SHUFFLE, 8'h00, 1, 8'h00, STS_OK,    4)); // LCG carried on
        dir_rows.push_back(mk_row(CMD_DRAW,    8'h00, 0, 8'h00, STS_OK,    0));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[ix])
            issue_cmd(dir_rows[ix].beat, dir_rows[ix].known, dir_rows[ix].want);

        // Random part: mostly well-formed rounds (clear, fill, shuffle, draw)
        // with random content, some raw noise, and one run to a full store.
        while (rand_sent < ITEMS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (!full_done && rand_sent >= 200)
            begin
                // fill to the limit, overrun it, shuffle the whole store
                full_done = 1'b1;
                push_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)));
                repeat (DEPTH + 3) push_cmd(CMD_APPEND, 8'($urandom_range(0, 255)));
                push_cmd(CMD_SHUFFLE, 8'($urandom_range(0, 255)));
                repeat (24) push_cmd(CMD_DRAW, 8'($urandom_range(0, 255)));
                push_cmd(CMD_SHUFFLE, 8'($urandom_range(0, 255)));
                repeat (8) push_cmd(CMD_DRAW, 8'($urandom_range(0, 255)));
                push_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)));
            end
            else if ($urandom_range(0, 6) != 0)
            begin
                // keep shuffle lengths small unless a round deliberately grows
                if (mirror_count > 60 || $urandom_range(0, 2) == 0)
                    push_cmd(CMD_CLEAR, 8'($urandom_range(0, 255)));
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48)
                                                 : $urandom_range(0, 12);
                repeat (n) push_cmd(CMD_APPEND, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 2))
                    push_cmd(CMD_SHUFFLE, 8'($urandom_range(0, 255)));
                left  = mirror_count - mirror_pos;
                // either drain and overrun a little, or stop partway
                draws = $urandom_range(0, 1) ? left + $urandom_range(0, 2)
                                             : $urandom_range(0, left);
                repeat (draws) push_cmd(CMD_DRAW, 8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                    push_cmd(lfyd_cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
        cmd_valid <= 1'b0;

        // drain, then leave room for any stray beat after the last one owed
        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_cnt == 0 && due_rsp.size() == 0)
            $display("tb_lcg_fisher_yates_deck: PASS");
        else
            $display("tb_lcg_fisher_yates_deck: FAIL");
        $finish;
    end

endmodule

FILE: sim.f
sv/lfyd_pkg.sv
sv/lfyd_ctrl.sv
sv/lfyd_dpath.sv
sv/lcg_fisher_yates_deck.sv
bench/tb_lcg_fisher_yates_deck.sv
